[rtl/affine_least_squares_fit_macros.svh]
// assertion macros for the affine least squares fit checker
`ifndef AFFINE_LEAST_SQUARES_FIT_MACROS_SVH
`define AFFINE_LEAST_SQUARES_FIT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define ALSF_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("alsf check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define ALSF_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("alsf check failed");

`endif

[rtl/alsf_pkg.sv]
// shared constants, command types and solve program for the affine fit
package alsf_pkg;

    localparam int DEF_MAX_POINTS = 4096;
    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int COEF_W = 32;
    localparam int IDX_W  = 3;
    localparam logic [IDX_W-1:0] IDX_LAST = 3'd5;

    localparam int AW        = 5;
    localparam int MEM_DEPTH = 20;
    localparam int PC_W      = 7;
    localparam int OP_W      = 3;
    localparam int NUM_LOADS = 12;

    localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
    localparam logic [OP_W-1:0] OP_ACCUM = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLR   = 3'd3;
    localparam logic [OP_W-1:0] OP_MAC   = 3'd4;
    localparam logic [OP_W-1:0] OP_STORE = 3'd5;
    localparam logic [OP_W-1:0] OP_DIV   = 3'd6;
    localparam logic [OP_W-1:0] OP_END   = 3'd7;

    // scratch memory map
    localparam logic [AW-1:0] A_SXX = 5'd0;
    localparam logic [AW-1:0] A_SXY = 5'd1;
    localparam logic [AW-1:0] A_SX  = 5'd2;
    localparam logic [AW-1:0] A_SYY = 5'd3;
    localparam logic [AW-1:0] A_SY  = 5'd4;
    localparam logic [AW-1:0] A_N   = 5'd5;
    localparam logic [AW-1:0] A_SXU = 5'd6;
    localparam logic [AW-1:0] A_SYU = 5'd7;
    localparam logic [AW-1:0] A_SU  = 5'd8;
    localparam logic [AW-1:0] A_SXV = 5'd9;
    localparam logic [AW-1:0] A_SYV = 5'd10;
    localparam logic [AW-1:0] A_SV  = 5'd11;
    localparam logic [AW-1:0] A_C00 = 5'd12;
    localparam logic [AW-1:0] A_C01 = 5'd13;
    localparam logic [AW-1:0] A_C02 = 5'd14;
    localparam logic [AW-1:0] A_C11 = 5'd15;
    localparam logic [AW-1:0] A_C12 = 5'd16;
    localparam logic [AW-1:0] A_C22 = 5'd17;
    localparam logic [AW-1:0] A_DET = 5'd18;
    localparam logic [AW-1:0] A_NUM = 5'd19;

    typedef struct packed {
        logic            valid;
        logic [OP_W-1:0] op;
        logic [AW-1:0]   a;
        logic [AW-1:0]   b;
        logic            neg;
        logic [AW-1:0]   dst;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_stat;

    function automatic t_cmd mk(input logic [OP_W-1:0] op, input logic [AW-1:0] a,
                                input logic [AW-1:0] b, input logic neg,
                                input logic [AW-1:0] dst);
        t_cmd c;
        c.valid = 1'b0;
        c.op    = op;
        c.a     = a;
        c.b     = b;
        c.neg   = neg;
        c.dst   = dst;
        return c;
    endfunction

    function automatic t_cmd mac(input logic [AW-1:0] a, input logic [AW-1:0] b,
                                 input logic neg);
        return mk(OP_MAC, a, b, neg, A_SXX);
    endfunction

    function automatic t_cmd st(input logic [AW-1:0] dst);
        return mk(OP_STORE, A_SXX, A_SXX, 1'b0, dst);
    endfunction

    function automatic t_cmd clr();
        return mk(OP_CLR, A_SXX, A_SXX, 1'b0, A_SXX);
    endfunction

    // moment loads, cofactors, determinant, then one numerator and quotient per coefficient
    function automatic t_cmd prog_step(input logic [PC_W-1:0] pc);
        t_cmd c;
        if (pc < PC_W'(NUM_LOADS)) begin
            c = mk(OP_LOAD, A_SXX, A_SXX, 1'b0, AW'(pc));
        end else begin
            unique case (pc)
                7'd12: c = clr();
                7'd13: c = mac(A_SYY, A_N, 1'b0);
                7'd14: c = mac(A_SY, A_SY, 1'b1);
                7'd15: c = st(A_C00);
                7'd16: c = clr();
                7'd17: c = mac(A_SXY, A_N, 1'b1);
                7'd18: c = mac(A_SY, A_SX, 1'b0);
                7'd19: c = st(A_C01);
                7'd20: c = clr();
                7'd21: c = mac(A_SXY, A_SY, 1'b0);
                7'd22: c = mac(A_SYY, A_SX, 1'b1);
                7'd23: c = st(A_C02);
                7'd24: c = clr();
                7'd25: c = mac(A_SXX, A_N, 1'b0);
                7'd26: c = mac(A_SX, A_SX, 1'b1);
                7'd27: c = st(A_C11);
                7'd28: c = clr();
                7'd29: c = mac(A_SXX, A_SY, 1'b1);
                7'd30: c = mac(A_SXY, A_SX, 1'b0);
                7'd31: c = st(A_C12);
                7'd32: c = clr();
                7'd33: c = mac(A_SXX, A_SYY, 1'b0);
                7'd34: c = mac(A_SXY, A_SXY, 1'b1);
                7'd35: c = st(A_C22);
                7'd36: c = clr();
                7'd37: c = mac(A_SXX, A_C00, 1'b0);
                7'd38: c = mac(A_SXY, A_C01, 1'b0);
                7'd39: c = mac(A_SX, A_C02, 1'b0);
                7'd40: c = st(A_DET);
                // a
                7'd41: c = clr();
                7'd42: c = mac(A_SXU, A_C00, 1'b0);
                7'd43: c = mac(A_SYU, A_C01, 1'b0);
                7'd44: c = mac(A_SU, A_C02, 1'b0);
                7'd45: c = st(A_NUM);
                7'd46: c = mk(OP_DIV, A_NUM, A_DET, 1'b0, A_SXX);
                // b
                7'd47: c = clr();
                7'd48: c = mac(A_SXU, A_C01, 1'b0);
                7'd49: c = mac(A_SYU, A_C11, 1'b0);
                7'd50: c = mac(A_SU, A_C12, 1'b0);
                7'd51: c = st(A_NUM);
                7'd52: c = mk(OP_DIV, A_NUM, A_DET, 1'b0, A_SXX);
                // c
                7'd53: c = clr();
                7'd54: c = mac(A_SXV, A_C00, 1'b0);
                7'd55: c = mac(A_SYV, A_C01, 1'b0);
                7'd56: c = mac(A_SV, A_C02, 1'b0);
                7'd57: c = st(A_NUM);
                7'd58: c = mk(OP_DIV, A_NUM, A_DET, 1'b0, A_SXX);
                // d
                7'd59: c = clr();
                7'd60: c = mac(A_SXV, A_C01, 1'b0);
                7'd61: c = mac(A_SYV, A_C11, 1'b0);
                7'd62: c = mac(A_SV, A_C12, 1'b0);
                7'd63: c = st(A_NUM);
                7'd64: c = mk(OP_DIV, A_NUM, A_DET, 1'b0, A_SXX);
                // tx
                7'd65: c = clr();
                7'd66: c = mac(A_SXU, A_C02, 1'b0);
                7'd67: c = mac(A_SYU, A_C12, 1'b0);
                7'd68: c = mac(A_SU, A_C22, 1'b0);
                7'd69: c = st(A_NUM);
                7'd70: c = mk(OP_DIV, A_NUM, A_DET, 1'b0, A_SXX);
                // ty
                7'd71: c = clr();
                7'd72: c = mac(A_SXV, A_C02, 1'b0);
                7'd73: c = mac(A_SYV, A_C12, 1'b0);
                7'd74: c = mac(A_SV, A_C22, 1'b0);
                7'd75: c = st(A_NUM);
                7'd76: c = mk(OP_DIV, A_NUM, A_DET, 1'b0, A_SXX);
                default: c = mk(OP_END, A_SXX, A_SXX, 1'b0, A_SXX);
            endcase
        end
        return c;
    endfunction

endpackage

[rtl/alsf_ctrl.sv]
// sequencer that accepts points and steps through the solve program
module alsf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_last_point,
    output logic             o_in_ready,
    input  alsf_pkg::t_stat  i_stat,
    output alsf_pkg::t_cmd   o_cmd
);
    import alsf_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic            r_state;
    logic [PC_W-1:0] r_pc;
    t_cmd            w_step;

    assign w_step     = prog_step(r_pc);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd = w_step;
        unique case (r_state)
            S_IDLE: begin
                o_cmd       = mk(OP_ACCUM, A_SXX, A_SXX, 1'b0, A_SXX);
                o_cmd.valid = i_in_valid;
            end
            S_RUN: begin
                o_cmd.valid = !i_stat.busy;
            end
            default: o_cmd.valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_last_point) begin
                        r_state <= S_RUN;
                        r_pc    <= '0;
                    end
                end
                S_RUN: begin
                    if (!i_stat.busy) begin
                        if (w_step.op == OP_END) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pc <= r_pc + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/alsf_datapath.sv]
// moment accumulators, scratch memory, serial multiplier and divider, output word
module alsf_datapath #(
    parameter int MAX_POINTS = alsf_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = alsf_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = alsf_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  alsf_pkg::t_cmd                      i_cmd,
    output alsf_pkg::t_stat                     o_stat,
    input  logic signed [COORD_BITS-1:0]        i_src_x,
    input  logic signed [COORD_BITS-1:0]        i_src_y,
    input  logic signed [COORD_BITS-1:0]        i_dst_x,
    input  logic signed [COORD_BITS-1:0]        i_dst_y,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [alsf_pkg::IDX_W-1:0]          o_coef_index,
    output logic signed [alsf_pkg::COEF_W-1:0]  o_coef_value,
    output logic                                o_fit_status,
    output logic                                o_last_coef
);
    import alsf_pkg::*;

    localparam int L  = $clog2(MAX_POINTS);
    localparam int SW = 2 * COORD_BITS + L;
    localparam int FW = COORD_BITS + L + 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PW = 2 * COORD_BITS;
    localparam int WW = 3 * SW + FRAC_BITS + 5;
    localparam int KW = $clog2(WW);

    localparam logic [2:0] P_IDLE  = 3'd0;
    localparam logic [2:0] P_SETUP = 3'd1;
    localparam logic [2:0] P_MUL   = 3'd2;
    localparam logic [2:0] P_DIV   = 3'd3;
    localparam logic [2:0] P_EMIT  = 3'd4;

    // moment sums
    logic signed [SW-1:0] r_sxx, r_sxy, r_syy, r_sxu, r_syu, r_sxv, r_syv;
    logic signed [FW-1:0] r_sx, r_sy, r_su, r_sv;
    logic [CW-1:0]        r_cnt;
    logic signed [PW-1:0] w_xx, w_xy, w_yy, w_xu, w_yu, w_xv, w_yv;

    // scratch memory
    logic signed [WW-1:0] r_mem [MEM_DEPTH];
    logic signed [WW-1:0] r_rd_a, r_rd_b;
    logic                 w_we;
    logic signed [WW-1:0] w_wd, w_ld;

    // serial units
    logic [2:0]           r_phase;
    logic [OP_W-1:0]      r_op;
    logic                 r_neg;
    logic [KW-1:0]        r_k;
    logic signed [WW-1:0] r_acc, r_mcand;
    logic [WW-1:0]        r_mplier;
    logic [WW-1:0]        r_quo, r_rem, r_dvsr;
    logic                 r_sign, r_singular;
    logic [WW-1:0]        w_abs_a, w_abs_b;
    logic [WW:0]          w_trial, w_diff;
    logic [WW-1:0]        n_rem, n_quo;
    logic                 w_step_done;

    // result shaping
    logic [COEF_W-1:0]    w_lim, w_mag;
    logic                 w_hi;
    logic signed [COEF_W-1:0] w_coef;

    // output word
    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_idx, r_out_index;
    logic signed [COEF_W-1:0] r_out_value;
    logic                 r_out_status, r_out_last;

    assign w_xx = i_src_x * i_src_x;
    assign w_xy = i_src_x * i_src_y;
    assign w_yy = i_src_y * i_src_y;
    assign w_xu = i_src_x * i_dst_x;
    assign w_yu = i_src_y * i_dst_x;
    assign w_xv = i_src_x * i_dst_y;
    assign w_yv = i_src_y * i_dst_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sxx <= '0; r_sxy <= '0; r_syy <= '0; r_sxu <= '0;
            r_syu <= '0; r_sxv <= '0; r_syv <= '0;
            r_sx  <= '0; r_sy  <= '0; r_su  <= '0; r_sv  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.valid && i_cmd.op == OP_END) begin
            r_sxx <= '0; r_sxy <= '0; r_syy <= '0; r_sxu <= '0;
            r_syu <= '0; r_sxv <= '0; r_syv <= '0;
            r_sx  <= '0; r_sy  <= '0; r_su  <= '0; r_sv  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.valid && i_cmd.op == OP_ACCUM && r_cnt < CW'(MAX_POINTS)) begin
            r_sxx <= r_sxx + SW'(w_xx);
            r_sxy <= r_sxy + SW'(w_xy);
            r_syy <= r_syy + SW'(w_yy);
            r_sxu <= r_sxu + SW'(w_xu);
            r_syu <= r_syu + SW'(w_yu);
            r_sxv <= r_sxv + SW'(w_xv);
            r_syv <= r_syv + SW'(w_yv);
            r_sx  <= r_sx + FW'(i_src_x);
            r_sy  <= r_sy + FW'(i_src_y);
            r_su  <= r_su + FW'(i_dst_x);
            r_sv  <= r_sv + FW'(i_dst_y);
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        unique case (i_cmd.dst)
            A_SXX:   w_ld = WW'(r_sxx);
            A_SXY:   w_ld = WW'(r_sxy);
            A_SX:    w_ld = WW'(r_sx);
            A_SYY:   w_ld = WW'(r_syy);
            A_SY:    w_ld = WW'(r_sy);
            A_N:     w_ld = WW'(r_cnt);
            A_SXU:   w_ld = WW'(r_sxu);
            A_SYU:   w_ld = WW'(r_syu);
            A_SU:    w_ld = WW'(r_su);
            A_SXV:   w_ld = WW'(r_sxv);
            A_SYV:   w_ld = WW'(r_syv);
            A_SV:    w_ld = WW'(r_sv);
            default: w_ld = '0;
        endcase
    end

    assign w_we = i_cmd.valid && (i_cmd.op == OP_LOAD || i_cmd.op == OP_STORE);
    assign w_wd = (i_cmd.op == OP_LOAD) ? w_ld : r_acc;

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_cmd.a];
        r_rd_b <= r_mem[i_cmd.b];
        if (w_we) begin
            r_mem[i_cmd.dst] <= w_wd;
        end
    end

    assign w_abs_a = r_rd_a[WW-1] ? WW'(-r_rd_a) : WW'(r_rd_a);
    assign w_abs_b = r_rd_b[WW-1] ? WW'(-r_rd_b) : WW'(r_rd_b);

    assign w_trial = {r_rem, r_quo[WW-1]};
    assign w_diff  = w_trial - {1'b0, r_dvsr};
    assign n_rem   = w_diff[WW] ? w_trial[WW-1:0] : w_diff[WW-1:0];
    assign n_quo   = {r_quo[WW-2:0], !w_diff[WW]};

    assign w_step_done = (r_k == KW'(WW - 1));

    assign w_hi   = |r_quo[WW-1:COEF_W];
    assign w_lim  = r_sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign w_mag  = (w_hi || r_quo[COEF_W-1:0] > w_lim) ? w_lim : r_quo[COEF_W-1:0];
    assign w_coef = r_singular ? '0 : (r_sign ? -$signed(w_mag) : $signed(w_mag));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_phase)
                P_IDLE: begin
                    if (i_cmd.valid && (i_cmd.op == OP_MAC || i_cmd.op == OP_DIV)) begin
                        r_phase <= P_SETUP;
                    end
                end
                P_SETUP: begin
                    if (r_op == OP_DIV) begin
                        r_phase <= r_singular ? P_EMIT : P_DIV;
                    end else begin
                        r_phase <= P_MUL;
                    end
                end
                P_MUL: if (w_step_done) r_phase <= P_IDLE;
                P_DIV: if (w_step_done) r_phase <= P_EMIT;
                P_EMIT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_idx       <= (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
                        r_phase     <= P_IDLE;
                    end
                end
                default: r_phase <= P_IDLE;
            endcase
            if (i_cmd.valid && i_cmd.op == OP_END) begin
                r_idx <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && (i_cmd.op == OP_MAC || i_cmd.op == OP_DIV)) begin
            r_op  <= i_cmd.op;
            r_neg <= i_cmd.neg;
        end
        if (i_cmd.valid && i_cmd.op == OP_CLR) begin
            r_acc <= '0;
        end
        if (i_cmd.valid && i_cmd.op == OP_STORE && i_cmd.dst == A_DET) begin
            r_singular <= (r_acc == '0);
        end
        unique case (r_phase)
            P_SETUP: begin
                r_k <= '0;
                if (r_op == OP_DIV) begin
                    r_sign <= r_rd_a[WW-1] ^ r_rd_b[WW-1];
                    r_quo  <= w_abs_a << FRAC_BITS;
                    r_dvsr <= w_abs_b;
                    r_rem  <= '0;
                end else begin
                    r_mcand  <= r_rd_a;
                    r_mplier <= r_rd_b;
                end
            end
            P_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= r_neg ? r_acc - r_mcand : r_acc + r_mcand;
                end
                r_mcand  <= r_mcand <<< 1;
                r_mplier <= r_mplier >> 1;
                r_k      <= r_k + 1'b1;
            end
            P_DIV: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_k   <= r_k + 1'b1;
            end
            P_EMIT: begin
                if (!r_out_valid) begin
                    r_out_value  <= w_coef;
                    r_out_status <= r_singular;
                    r_out_index  <= r_idx;
                    r_out_last   <= (r_idx == IDX_LAST);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.busy  = (r_phase != P_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_coef_index = r_out_index;
    assign o_coef_value = r_out_value;
    assign o_fit_status = r_out_status;
    assign o_last_coef  = r_out_last;

endmodule

[rtl/affine_least_squares_fit.sv]
// A point that is not last is taken while the block is idle, one point per cycle.
// A last point starts the solve, which runs on the bit-serial multiplier (33 products)
// and the restoring divider (6 quotients) over scratch words of WW bits,
// WW = 3*(2*COORD_BITS+log2(MAX_POINTS))+FRAC_BITS+5 (129 by default).
// No point is taken during the solve; output words wait in a one-deep output register.
// Reset (synchronous, active low) clears the sums, the count and the output valid.
module affine_least_squares_fit #(
    parameter int MAX_POINTS = alsf_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = alsf_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = alsf_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [COORD_BITS-1:0]        i_src_x,
    input  logic signed [COORD_BITS-1:0]        i_src_y,
    input  logic signed [COORD_BITS-1:0]        i_dst_x,
    input  logic signed [COORD_BITS-1:0]        i_dst_y,
    input  logic                                i_last_point,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [alsf_pkg::IDX_W-1:0]          o_coef_index,
    output logic signed [alsf_pkg::COEF_W-1:0]  o_coef_value,
    output logic                                o_fit_status,
    output logic                                o_last_coef
);
    import alsf_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    alsf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_point (i_last_point),
        .o_in_ready   (o_in_ready),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    alsf_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_src_x      (i_src_x),
        .i_src_y      (i_src_y),
        .i_dst_x      (i_dst_x),
        .i_dst_y      (i_dst_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_coef_index (o_coef_index),
        .o_coef_value (o_coef_value),
        .o_fit_status (o_fit_status),
        .o_last_coef  (o_last_coef)
    );

endmodule

[rtl/alsf_checker.sv]
// port-level checks on the fit output channel, bound to the top level
`include "affine_least_squares_fit_macros.svh"

module alsf_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic [alsf_pkg::IDX_W-1:0]          o_coef_index,
    input  logic signed [alsf_pkg::COEF_W-1:0]  o_coef_value,
    input  logic                                o_fit_status,
    input  logic                                o_last_coef
);
    import alsf_pkg::*;

    `ALSF_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_coef_value) && $stable(o_coef_index))
    `ALSF_ASSERT_IMP(a_last_mark, o_out_valid, o_last_coef == (o_coef_index == IDX_LAST))
    `ALSF_ASSERT_IMP(a_idx_range, o_out_valid, o_coef_index <= IDX_LAST)
    `ALSF_ASSERT_IMP(a_singular_zero, o_out_valid && o_fit_status, o_coef_value == '0)

endmodule

bind affine_least_squares_fit alsf_checker u_alsf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_coef_index (o_coef_index),
    .o_coef_value (o_coef_value),
    .o_fit_status (o_fit_status),
    .o_last_coef  (o_last_coef)
);
